### rtl/core/rational_arithmetic_unit_assert.svh
// assertion macros for the rational arithmetic unit
`ifndef RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH
`define RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define RAU_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define RAU_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define RAU_ASSERT_IMPL(label, clk, rst, ante, cons)
`define RAU_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### rtl/core/rau_pkg.sv
// shared types and codes for the rational arithmetic unit
package rau_pkg;
  localparam int W = 32;

  typedef enum logic [2:0] {
    FUNC_ADD = 3'd0,
    FUNC_SUB = 3'd1,
    FUNC_MUL = 3'd2,
    FUNC_DIV = 3'd3,
    FUNC_EQ  = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    ERR_OK       = 2'd0,
    ERR_ZERO_DEN = 2'd1,
    ERR_DIV_ZERO = 2'd2
  } err_t;

  typedef struct packed {
    logic [2:0]     func;
    logic [W-1:0]   left_num;
    logic [W-1:0]   left_den;
    logic [W-1:0]   right_num;
    logic [W-1:0]   right_den;
  } in_beat_t;

  typedef struct packed {
    logic [W-1:0]   res_num;
    logic [W-1:0]   res_den;
    logic           is_equal;
    logic [1:0]     error_code;
  } out_beat_t;

  // divider command / status
  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

  typedef enum logic [4:0] {
    S_IDLE, S_CHK,
    S_G1, S_G1W, S_R1N, S_R1NW, S_R1D, S_R1DW,
    S_G2, S_G2W, S_R2N, S_R2NW, S_R2D, S_R2DW,
    S_OP,
    S_LG, S_LGW, S_LCD, S_LCDW, S_LA, S_LAW, S_LB, S_LBW, S_LSUM,
    S_FIN,
    S_GR, S_GRW, S_RRN, S_RRNW, S_RRD, S_RRDW,
    S_OUT
  } state_t;
endpackage

### rtl/core/rau_divider.sv
// shared restoring divider, one quotient bit per cycle, truncating signed
module rau_divider import rau_pkg::*; #(
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  div_ctl_t      ctl,
  input  logic [DW-1:0] a,
  input  logic [DW-1:0] b,
  output div_sts_t      sts,
  output logic [DW-1:0] quo,
  output logic [DW-1:0] rem
);
  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] dvd, dvs, q;
  logic [DW:0]   r;
  logic [CW-1:0] cnt;
  logic          neg_q, neg_r, busy, done;
  logic [DW:0]   r_sh, r_sub;

  assign r_sh  = {r[DW-1:0], dvd[DW-1]};
  assign r_sub = r_sh - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy  <= 1'b1;
        dvd   <= a[DW-1] ? -a : a;
        dvs   <= b[DW-1] ? -b : b;
        neg_q <= a[DW-1] ^ b[DW-1];
        neg_r <= a[DW-1];
        r     <= '0;
        q     <= '0;
        cnt   <= CW'(DW);
      end else if (busy) begin
        dvd <= {dvd[DW-2:0], 1'b0};
        if (!r_sub[DW]) begin
          r <= r_sub;
          q <= {q[DW-2:0], 1'b1};
        end else begin
          r <= r_sh;
          q <= {q[DW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quo = neg_q ? -q : q;
  assign rem = neg_r ? -r[DW-1:0] : r[DW-1:0];
  assign sts = '{busy: busy, done: done};
endmodule

### rtl/core/rau_seq.sv
// sequencer: gcd loops, reductions and operation steps over the divider
module rau_seq import rau_pkg::*; #(
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  in_beat_t      in_data,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output out_beat_t     out_data,
  output div_ctl_t      dctl,
  output logic [DW-1:0] da,
  output logic [DW-1:0] db,
  input  div_sts_t      dsts,
  input  logic [DW-1:0] dquo,
  input  logic [DW-1:0] drem
);
`include "rational_arithmetic_unit_assert.svh"

  state_t state, state_next;
  logic [2:0]    func;
  logic [DW-1:0] n1, d1, n2, d2, ga, gb, cd, ta, rn, rd;
  err_t          err;
  logic [DW-1:0] mul_a, mul_b, mul_p;
  logic [2*DW-1:0] mul_full;

  // one shared wrapping multiplier
  assign mul_full = mul_a * mul_b;
  assign mul_p    = mul_full[DW-1:0];

  always_comb begin
    mul_a = n1;
    mul_b = d2;
    unique case (state)
      S_LG:   begin mul_a = d1; mul_b = d2; end
      S_LAW:  begin mul_a = n1; mul_b = dquo; end
      S_LBW:  begin mul_a = n2; mul_b = dquo; end
      S_OP:   begin
        if (func == FUNC_MUL) begin mul_a = n1; mul_b = n2; end
        else begin mul_a = n1; mul_b = d2; end
      end
      S_FIN:  begin
        if (func == FUNC_MUL) begin mul_a = d1; mul_b = d2; end
        else begin mul_a = d1; mul_b = n2; end
      end
      // second cross product for the equality test
      S_OUT:  begin mul_a = d1; mul_b = n2; end
      default: begin mul_a = n1; mul_b = d2; end
    endcase
  end

  // divider start and operands
  always_comb begin
    dctl.start = 1'b0;
    da = ga;
    db = gb;
    unique case (state)
      S_G1, S_G2, S_LG, S_GR: begin dctl.start = (gb != '0); end
      S_R1N: begin dctl.start = 1'b1; da = n1; db = ga; end
      S_R1D: begin dctl.start = 1'b1; da = d1; db = ga; end
      S_R2N: begin dctl.start = 1'b1; da = n2; db = ga; end
      S_R2D: begin dctl.start = 1'b1; da = d2; db = ga; end
      S_LCD: begin dctl.start = 1'b1; da = ta; db = ga; end
      S_LA:  begin dctl.start = 1'b1; da = cd; db = d1; end
      S_LB:  begin dctl.start = 1'b1; da = cd; db = d2; end
      S_RRN: begin dctl.start = 1'b1; da = rn; db = ga; end
      S_RRD: begin dctl.start = 1'b1; da = rd; db = ga; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_CHK;
      S_CHK:  state_next = (d1 == '0 || d2 == '0) ? S_OUT : S_G1;
      S_G1:   state_next = (gb == '0) ? S_R1N : S_G1W;
      S_G1W:  if (dsts.done) state_next = S_G1;
      S_R1N:  state_next = S_R1NW;
      S_R1NW: if (dsts.done) state_next = S_R1D;
      S_R1D:  state_next = S_R1DW;
      S_R1DW: if (dsts.done) state_next = S_G2;
      S_G2:   state_next = (gb == '0) ? S_R2N : S_G2W;
      S_G2W:  if (dsts.done) state_next = S_G2;
      S_R2N:  state_next = S_R2NW;
      S_R2NW: if (dsts.done) state_next = S_R2D;
      S_R2D:  state_next = S_R2DW;
      S_R2DW: if (dsts.done) state_next = S_OP;
      S_OP: begin
        unique case (func)
          FUNC_ADD, FUNC_SUB: state_next = S_LG;
          FUNC_MUL:           state_next = S_FIN;
          FUNC_DIV:           state_next = (n2 == '0) ? S_OUT : S_FIN;
          default:            state_next = S_OUT;
        endcase
      end
      S_LG:   state_next = (gb == '0) ? S_LCD : S_LGW;
      S_LGW:  if (dsts.done) state_next = S_LG;
      S_LCD:  state_next = S_LCDW;
      S_LCDW: if (dsts.done) state_next = S_LA;
      S_LA:   state_next = S_LAW;
      S_LAW:  if (dsts.done) state_next = S_LB;
      S_LB:   state_next = S_LBW;
      S_LBW:  if (dsts.done) state_next = S_LSUM;
      S_LSUM: state_next = (cd == '0) ? S_OUT : S_GR;
      S_FIN:  state_next = (mul_p == '0) ? S_OUT : S_GR;
      S_GR:   state_next = (gb == '0) ? S_RRN : S_GRW;
      S_GRW:  if (dsts.done) state_next = S_GR;
      S_RRN:  state_next = S_RRNW;
      S_RRNW: if (dsts.done) state_next = S_RRD;
      S_RRD:  state_next = S_RRDW;
      S_RRDW: if (dsts.done) state_next = S_OUT;
      S_OUT:  if (!out_stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: if (in_valid) begin
        func <= in_data.func;
        n1 <= in_data.left_num;  d1 <= in_data.left_den;
        n2 <= in_data.right_num; d2 <= in_data.right_den;
        rn <= '0; rd <= {{(DW-1){1'b0}}, 1'b1};
        err <= ERR_OK;
      end
      S_CHK: begin
        if (d1 == '0 || d2 == '0) err <= ERR_ZERO_DEN;
        ga <= n1; gb <= d1;
      end
      S_G1W, S_G2W, S_LGW, S_GRW: if (dsts.done) begin ga <= gb; gb <= drem; end
      S_R1NW: if (dsts.done) n1 <= dquo;
      S_R1DW: if (dsts.done) begin d1 <= dquo; ga <= n2; gb <= d2; end
      S_R2NW: if (dsts.done) n2 <= dquo;
      S_R2DW: if (dsts.done) d2 <= dquo;
      S_OP: begin
        if (func == FUNC_DIV && n2 == '0) err <= ERR_DIV_ZERO;
        if (func == FUNC_EQ) ta <= mul_p;
        if (func == FUNC_MUL || func == FUNC_DIV) rn <= mul_p;
        if (func == FUNC_ADD || func == FUNC_SUB) begin ga <= d1; gb <= d2; end
      end
      S_LG:   ta <= mul_p;
      S_LCDW: if (dsts.done) cd <= dquo;
      S_LAW:  if (dsts.done) ta <= mul_p;
      S_LBW:  if (dsts.done) rn <= (func == FUNC_ADD) ? ta + mul_p : ta - mul_p;
      S_LSUM: begin
        if (cd == '0) begin err <= ERR_ZERO_DEN; rn <= '0; end
        else begin rd <= cd; ga <= rn; gb <= cd; end
      end
      S_FIN: begin
        if (mul_p == '0) err <= ERR_ZERO_DEN;
        else begin rd <= mul_p; ga <= rn; gb <= mul_p; end
        if (mul_p == '0) rn <= '0;
      end
      S_RRNW: if (dsts.done) rn <= dquo;
      S_RRDW: if (dsts.done) rd <= dquo;
      default: ;
    endcase
  end

  // equality: first cross product held in ta, second formed while the result waits
  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_OUT);
  always_comb begin
    out_data.res_num    = rn;
    out_data.res_den    = rd;
    out_data.is_equal   = (err == ERR_OK && func == FUNC_EQ) ? (ta == mul_p) : 1'b0;
    out_data.error_code = err;
    if (err != ERR_OK) begin
      out_data.res_num = '0;
      out_data.res_den = {{(DW-1){1'b0}}, 1'b1};
    end
  end

  `RAU_ASSERT_IMPL(a_busy_stall, clk, rst, state != S_IDLE, in_stall)
  `RAU_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_data))
  `RAU_ASSERT_IMPL(a_div_idle_start, clk, rst, dctl.start, !dsts.busy)
  `RAU_ASSERT_IMPL(a_err_no_eq, clk, rst, out_valid && err != ERR_OK, !out_data.is_equal)
endmodule

### rtl/core/rational_arithmetic_unit.sv
// top level of the rational arithmetic unit
// a zero-denominator beat goes from S_CHK straight to S_OUT; otherwise the beat issues each
// division to the bit-serial divider and waits on it, from six divisions up to about 193
// divisions when every euclidean loop runs longest
// throughput: one beat at a time; the input stalls until the result is taken
// reset: synchronous active-high rst returns the sequencer to idle, no result pending
module rational_arithmetic_unit import rau_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_data
);
  // payload width is fixed by the package struct
  localparam int DW = W;

  div_ctl_t      dctl;
  div_sts_t      dsts;
  logic [DW-1:0] da, db, dquo, drem;

  // sequencer walks gcd, reduction and operation steps
  rau_seq #(.DW(DW)) u_seq (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_data(in_data), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .dctl(dctl), .da(da), .db(db), .dsts(dsts), .dquo(dquo), .drem(drem)
  );

  // the one divider shared by every gcd step and reduction
  rau_divider #(.DW(DW)) u_div (
    .clk(clk), .rst(rst), .ctl(dctl), .a(da), .b(db),
    .sts(dsts), .quo(dquo), .rem(drem)
  );
endmodule
